// ----- rtl/gsw_pkg.sv -----
package gsw_pkg;

  // fixed point and grid constants
  localparam int UV_FRAC   = 16;
  localparam int UV_W      = UV_FRAC + 1;
  localparam int MAX_DIM   = 32;
  localparam int DIM_W     = 6;
  localparam int IDX_W     = 5;
  localparam int XY_W      = 32;
  localparam int FR_W      = 22;   // exit fraction numerator/denominator
  localparam int AB_W      = 24;   // signed axis terms
  localparam int DV_W      = 44;   // divider operands
  localparam int MA_W      = 34;
  localparam int MB_W      = 24;
  localparam int MP_W      = MA_W + MB_W;
  localparam int PIECE_W   = 6;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  // multiplier operand selects
  localparam logic [3:0] MOP_AU_SD = 4'd0;
  localparam logic [3:0] MOP_SN_BU = 4'd1;
  localparam logic [3:0] MOP_AV_SD = 4'd2;
  localparam logic [3:0] MOP_SN_BV = 4'd3;
  localparam logic [3:0] MOP_AU_BV = 4'd4;
  localparam logic [3:0] MOP_AV_BU = 4'd5;
  localparam logic [3:0] MOP_EN_SD = 4'd6;
  localparam logic [3:0] MOP_SN_ED = 4'd7;
  localparam logic [3:0] MOP_ED_DS = 4'd8;
  localparam logic [3:0] MOP_T_DX  = 4'd9;
  localparam logic [3:0] MOP_T_DY  = 4'd10;

  typedef struct packed {
    logic [UV_W-1:0]        start_u;
    logic [UV_W-1:0]        start_v;
    logic [UV_W-1:0]        end_u;
    logic [UV_W-1:0]        end_v;
    logic signed [XY_W-1:0] start_x;
    logic signed [XY_W-1:0] start_y;
    logic signed [XY_W-1:0] end_x;
    logic signed [XY_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [XY_W-1:0] piece_start_x;
    logic signed [XY_W-1:0] piece_start_y;
    logic signed [XY_W-1:0] piece_end_x;
    logic signed [XY_W-1:0] piece_end_y;
    logic [IDX_W-1:0]       cell_col;
    logic [IDX_W-1:0]       cell_row;
    logic                   is_black;
    logic                   last_piece;
  } out_item_t;

  typedef struct packed {
    logic       load_in;
    logic       calc_ax;
    logic [3:0] mop;
    logic       hold_en;
    logic       set_vok;
    logic       set_hok;
    logic       sel;
    logic       force_last;
    logic       num_en;
    logic       div_init;
    logic       div_step;
    logic       t_rnd;
    logic       ex_en;
    logic       ey_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic sel_none;
    logic out_free;
    logic last;
  } sts_t;

endpackage

// ----- rtl/gsw_ctrl.sv -----
module gsw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gsw_pkg::sts_t sts,
  output gsw_pkg::cmd_t cmd
);
  import gsw_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_AX   = 5'd1;
  localparam logic [4:0] S_U1   = 5'd2;
  localparam logic [4:0] S_U2   = 5'd3;
  localparam logic [4:0] S_V1   = 5'd4;
  localparam logic [4:0] S_V2   = 5'd5;
  localparam logic [4:0] S_C1   = 5'd6;
  localparam logic [4:0] S_C2   = 5'd7;
  localparam logic [4:0] S_SEL  = 5'd8;
  localparam logic [4:0] S_N1   = 5'd9;
  localparam logic [4:0] S_N2   = 5'd10;
  localparam logic [4:0] S_N3   = 5'd11;
  localparam logic [4:0] S_N4   = 5'd12;
  localparam logic [4:0] S_DIV  = 5'd13;
  localparam logic [4:0] S_TRND = 5'd14;
  localparam logic [4:0] S_LX   = 5'd15;
  localparam logic [4:0] S_LY   = 5'd16;
  localparam logic [4:0] S_LY2  = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  localparam int DCNT_W = $clog2(UV_W + 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(UV_W - 1);
  localparam logic [PIECE_W-1:0] PIECE_MAX = '1;

  logic [4:0]         state_r, state_nxt;
  logic [PIECE_W-1:0] piece_r, piece_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    piece_nxt = piece_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    cmd.mop   = MOP_AU_SD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          piece_nxt   = '0;
          state_nxt   = S_AX;
        end
      end
      S_AX: begin
        cmd.calc_ax = 1'b1;
        state_nxt   = S_U1;
      end
      S_U1: begin
        cmd.mop   = MOP_AU_SD;
        state_nxt = S_U2;
      end
      S_U2: begin
        cmd.mop     = MOP_SN_BU;
        cmd.hold_en = 1'b1;
        state_nxt   = S_V1;
      end
      S_V1: begin
        cmd.mop     = MOP_AV_SD;
        cmd.set_vok = 1'b1;
        state_nxt   = S_V2;
      end
      S_V2: begin
        cmd.mop     = MOP_SN_BV;
        cmd.hold_en = 1'b1;
        state_nxt   = S_C1;
      end
      S_C1: begin
        cmd.mop     = MOP_AU_BV;
        cmd.set_hok = 1'b1;
        state_nxt   = S_C2;
      end
      S_C2: begin
        cmd.mop     = MOP_AV_BU;
        cmd.hold_en = 1'b1;
        state_nxt   = S_SEL;
      end
      S_SEL: begin
        cmd.sel        = 1'b1;
        cmd.force_last = (piece_r == PIECE_MAX);
        state_nxt      = (sts.sel_none || cmd.force_last) ? S_LX : S_N1;
      end
      S_N1: begin
        cmd.mop   = MOP_EN_SD;
        state_nxt = S_N2;
      end
      S_N2: begin
        cmd.mop     = MOP_SN_ED;
        cmd.hold_en = 1'b1;
        state_nxt   = S_N3;
      end
      S_N3: begin
        cmd.mop    = MOP_ED_DS;
        cmd.num_en = 1'b1;
        state_nxt  = S_N4;
      end
      S_N4: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == DIV_LAST) state_nxt = S_TRND;
      end
      S_TRND: begin
        cmd.t_rnd = 1'b1;
        state_nxt = S_LX;
      end
      S_LX: begin
        cmd.mop   = MOP_T_DX;
        state_nxt = S_LY;
      end
      S_LY: begin
        cmd.mop   = MOP_T_DY;
        cmd.ex_en = 1'b1;
        state_nxt = S_LY2;
      end
      S_LY2: begin
        cmd.ey_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            piece_nxt = piece_r + 1'b1;
            state_nxt = S_AX;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      piece_r <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      piece_r <= piece_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

// ----- rtl/gsw_dp.sv -----
module gsw_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gsw_pkg::in_item_t               in_data,
  input  logic [gsw_pkg::DIM_W-1:0]       cols,
  input  logic [gsw_pkg::DIM_W-1:0]       rows,
  input  gsw_pkg::cmd_t                   cmd,
  output gsw_pkg::sts_t                   sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gsw_pkg::out_item_t              out_data
);
  import gsw_pkg::*;

  localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << UV_FRAC;
  localparam logic [MP_W-1:0] HALF   = MP_W'(1) << (UV_FRAC - 1);

  // edge registers
  logic [UV_W-1:0]        su_r, sv_r;
  logic signed [UV_W:0]   du_r, dv_r;
  logic signed [XY_W-1:0] bx_r, by_r, cx_r, cy_r;
  logic [DIM_W-1:0]       ncol_r, nrow_r;
  logic [IDX_W-1:0]       ci_r, cj_r;
  logic [FR_W-1:0]        sn_r, sd_r, en_r, ed_r;
  logic signed [AB_W-1:0] au_r, bu_r, av_r, bv_r;
  logic                   ubase_r, vbase_r, vok_r, hok_r;
  logic                   none_r, isv_r;
  logic signed [MP_W-1:0] mul_r, hold_r;
  logic [DV_W-1:0]        num_r, den_r, rem_r;
  logic [UV_W-1:0]        q_r, t_r;
  logic                   ge_r;
  logic signed [XY_W-1:0] ex_r, ey_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  function automatic logic [UV_W-1:0] clamp_uv(input logic [UV_W-1:0] v);
    return (v > UV_ONE) ? UV_ONE : v;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [DIM_W+1:0] v,
                                                input logic [DIM_W-1:0] n);
    logic signed [DIM_W+1:0] top;
    top = $signed({2'b00, n}) - 8'sd1;
    if (v < 0) return '0;
    if (v > top) return top[IDX_W-1:0];
    return v[IDX_W-1:0];
  endfunction

  // start cell from floor(uv * n)
  function automatic logic [IDX_W-1:0] start_cell(input logic [UV_W-1:0] uv,
                                                 input logic [DIM_W-1:0] n);
    logic [UV_W+DIM_W-1:0] p;
    p = uv * n;
    return clamp_idx($signed({2'b00, p[UV_W+DIM_W-2:UV_FRAC]}), n);
  endfunction

  // round half away from zero, add to piece start
  function automatic logic signed [XY_W-1:0] lerp_end(input logic signed [MP_W-1:0] p,
                                                     input logic signed [XY_W-1:0] c);
    logic [MP_W-1:0]        mag;
    logic [MP_W-1:0]        r;
    logic signed [XY_W+2:0] sum;
    mag = p[MP_W-1] ? MP_W'(-p) : MP_W'(p);
    r   = (mag + HALF) >> UV_FRAC;
    if (p[MP_W-1]) sum = $signed({{3{c[XY_W-1]}}, c}) - $signed(r[XY_W+2:0]);
    else           sum = $signed({{3{c[XY_W-1]}}, c}) + $signed(r[XY_W+2:0]);
    return sum[XY_W-1:0];
  endfunction

  // exit line ahead on each axis: normalized a, b and usable flag
  logic signed [AB_W-1:0] au_c, bu_c, av_c, bv_c;
  logic                   ubase_c, vbase_c;

  always_comb begin
    logic [DIM_W-1:0]       line;
    logic [UV_W+DIM_W-1:0]  pn;
    logic signed [AB_W-1:0] a, b;
    line = (du_r > 0) ? DIM_W'(ci_r) + 1'b1 : DIM_W'(ci_r);
    pn   = su_r * ncol_r;
    a    = $signed(AB_W'({line, UV_FRAC'(0)})) - $signed(AB_W'(pn));
    b    = AB_W'(du_r * $signed({1'b0, ncol_r}));
    if (b < 0) begin
      a = -a;
      b = -b;
    end
    au_c    = a;
    bu_c    = b;
    ubase_c = (du_r != 0) && (a < b);

    line = (dv_r > 0) ? DIM_W'(cj_r) + 1'b1 : DIM_W'(cj_r);
    pn   = sv_r * nrow_r;
    a    = $signed(AB_W'({line, UV_FRAC'(0)})) - $signed(AB_W'(pn));
    b    = AB_W'(dv_r * $signed({1'b0, nrow_r}));
    if (b < 0) begin
      a = -a;
      b = -b;
    end
    av_c    = a;
    bv_c    = b;
    vbase_c = (dv_r != 0) && (a < b);
  end

  // shared multiplier operands
  logic signed [MA_W-1:0] opa;
  logic signed [MB_W-1:0] opb;
  logic [FR_W-1:0]        dsn;
  assign dsn = sd_r - sn_r;

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.mop)
      MOP_AU_SD: begin opa = MA_W'(au_r); opb = MB_W'(sd_r); end
      MOP_SN_BU: begin opa = MA_W'(sn_r); opb = bu_r; end
      MOP_AV_SD: begin opa = MA_W'(av_r); opb = MB_W'(sd_r); end
      MOP_SN_BV: begin opa = MA_W'(sn_r); opb = bv_r; end
      MOP_AU_BV: begin opa = MA_W'(au_r); opb = bv_r; end
      MOP_AV_BU: begin opa = MA_W'(av_r); opb = bu_r; end
      MOP_EN_SD: begin opa = MA_W'(en_r); opb = MB_W'(sd_r); end
      MOP_SN_ED: begin opa = MA_W'(sn_r); opb = MB_W'(ed_r); end
      MOP_ED_DS: begin opa = MA_W'(ed_r); opb = MB_W'(dsn); end
      MOP_T_DX:  begin
        opa = MA_W'($signed({bx_r[XY_W-1], bx_r}) - $signed({cx_r[XY_W-1], cx_r}));
        opb = MB_W'(t_r);
      end
      MOP_T_DY:  begin
        opa = MA_W'($signed({by_r[XY_W-1], by_r}) - $signed({cy_r[XY_W-1], cy_r}));
        opb = MB_W'(t_r);
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // exit choice: u line wins ties
  logic sel_u, sel_v;
  assign sel_u = vok_r && (!hok_r || (hold_r <= mul_r));
  assign sel_v = !sel_u && hok_r;

  // divider step
  logic [DV_W:0] r2;
  logic          r_ge;
  assign r2   = {rem_r, 1'b0};
  assign r_ge = (r2 >= {1'b0, den_r});

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  logic signed [DIM_W+1:0] ci_step, cj_step;
  assign ci_step = (du_r > 0) ? $signed({3'b000, ci_r}) + 8'sd1 : $signed({3'b000, ci_r}) - 8'sd1;
  assign cj_step = (dv_r > 0) ? $signed({3'b000, cj_r}) + 8'sd1 : $signed({3'b000, cj_r}) - 8'sd1;

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    mul_r <= opa * opb;
    if (cmd.load_in) begin
      su_r   <= clamp_uv(in_data.start_u);
      sv_r   <= clamp_uv(in_data.start_v);
      du_r   <= $signed({1'b0, clamp_uv(in_data.end_u)}) -
                $signed({1'b0, clamp_uv(in_data.start_u)});
      dv_r   <= $signed({1'b0, clamp_uv(in_data.end_v)}) -
                $signed({1'b0, clamp_uv(in_data.start_v)});
      bx_r   <= in_data.end_x;
      by_r   <= in_data.end_y;
      cx_r   <= in_data.start_x;
      cy_r   <= in_data.start_y;
      ncol_r <= cols;
      nrow_r <= rows;
      ci_r   <= start_cell(clamp_uv(in_data.start_u), cols);
      cj_r   <= start_cell(clamp_uv(in_data.start_v), rows);
      sn_r   <= '0;
      sd_r   <= FR_W'(1);
    end
    if (cmd.calc_ax) begin
      au_r    <= au_c;
      bu_r    <= bu_c;
      av_r    <= av_c;
      bv_r    <= bv_c;
      ubase_r <= ubase_c;
      vbase_r <= vbase_c;
    end
    if (cmd.hold_en) hold_r <= mul_r;
    if (cmd.set_vok) vok_r <= ubase_r && !(hold_r < mul_r);
    if (cmd.set_hok) hok_r <= vbase_r && !(hold_r < mul_r);
    if (cmd.sel) begin
      none_r <= cmd.force_last || (!sel_u && !sel_v);
      isv_r  <= sel_v;
      en_r   <= sel_u ? au_r[FR_W-1:0] : av_r[FR_W-1:0];
      ed_r   <= sel_u ? bu_r[FR_W-1:0] : bv_r[FR_W-1:0];
      t_r    <= UV_ONE;
    end
    if (cmd.num_en) num_r <= DV_W'(hold_r - mul_r);
    if (cmd.div_init) begin
      den_r <= mul_r[DV_W-1:0];
      rem_r <= num_r;
      q_r   <= '0;
      ge_r  <= (num_r >= mul_r[DV_W-1:0]);
    end
    if (cmd.div_step) begin
      rem_r <= r_ge ? DV_W'(r2 - {1'b0, den_r}) : r2[DV_W-1:0];
      q_r   <= {q_r[UV_W-2:0], r_ge};
    end
    if (cmd.t_rnd) t_r <= ge_r ? UV_ONE : UV_W'(({1'b0, q_r} + 1'b1) >> 1);
    if (cmd.ex_en) ex_r <= lerp_end(mul_r, cx_r);
    if (cmd.ey_en) ey_r <= lerp_end(mul_r, cy_r);
    if (cmd.out_load) begin
      out_r.piece_start_x <= cx_r;
      out_r.piece_start_y <= cy_r;
      out_r.piece_end_x   <= ex_r;
      out_r.piece_end_y   <= ey_r;
      out_r.cell_col      <= ci_r;
      out_r.cell_row      <= cj_r;
      out_r.is_black      <= ci_r[0] ^ cj_r[0];
      out_r.last_piece    <= none_r;
      if (!none_r) begin
        cx_r <= ex_r;
        cy_r <= ey_r;
        sn_r <= en_r;
        sd_r <= ed_r;
        if (!isv_r) ci_r <= clamp_idx(ci_step, ncol_r);
        else        cj_r <= clamp_idx(cj_step, nrow_r);
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.sel_none = !sel_u && !sel_v;
  assign sts.out_free = out_free;
  assign sts.last     = none_r;

endmodule

// ----- rtl/uv_grid_segment_walker.sv -----
// Pieces: each piece is worked out in the bit-serial exit fraction divider and on
//   one shared 34x24 multiplier; a final piece skips the divider, and the walk
//   waits while the output is stalled.
// Throughput: one edge at a time; the next edge is taken once its last piece is loaded.
// Reset: synchronous active-low; column and row counts return to 10.
module uv_grid_segment_walker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gsw_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gsw_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gsw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsw_pkg::DIM_W-1:0]         cfg_data
);
  import gsw_pkg::*;

  logic [DIM_W-1:0] cols_r, rows_r;
  logic [DIM_W-1:0] cols, rows;
  cmd_t             cmd;
  sts_t             sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= DIM_W'(10);
      rows_r <= DIM_W'(10);
    end else if (cfg_valid) begin
      if (cfg_index == REG_COLS) cols_r <= cfg_data;
      if (cfg_index == REG_ROWS) rows_r <= cfg_data;
    end
  end

  // zero counts as one, clamp to the largest grid
  assign cols = (cols_r == '0) ? DIM_W'(1) : (cols_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_r;
  assign rows = (rows_r == '0) ? DIM_W'(1) : (rows_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_r;

  gsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gsw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cols      (cols),
    .rows      (rows),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/gsw_checker.sv -----
module gsw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input gsw_pkg::out_item_t out_data
);
  import gsw_pkg::*;

  // a taken edge keeps the input closed while it is walked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not closed after item accepted");

  // a stalled piece holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output item changed");

  // checker color follows the cell indices
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_black == (out_data.cell_col[0] ^ out_data.cell_row[0])))
    else $error("is_black does not match cell parity");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind uv_grid_segment_walker gsw_checker u_gsw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
